// ----- rtl/kctd_pkg.sv -----
// ----------------------------------------------------------------------------
// kctd_pkg
// Shared constants and types of the key chord trigger detector.
// ----------------------------------------------------------------------------
package kctd_pkg;

    localparam int TRIGGERS         = 4;
    localparam int KEYS_PER_TRIGGER = 4;
    localparam int KEY_BITS         = 16;

    localparam int SLOT_BITS      = 16;
    localparam int CHORD_BITS     = 64;
    localparam int CHORD_REGS     = 4;
    localparam int COUNT_BITS     = 3;
    localparam int ENABLE_BITS    = 4;
    localparam int COUNTS_BITS    = 12;
    localparam int FIRED_BITS     = 4;
    localparam int CODE_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNTS     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHORD_KEYS_0   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHORD_KEYS_1   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHORD_KEYS_2   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHORD_KEYS_3   = 3'd5;

    localparam logic KIND_DOWN = 1'b0;
    localparam logic KIND_UP   = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic                  is_repeat;
        logic [KEY_BITS-1:0]   key;
        logic [FIRED_BITS-1:0] fired;
    } event_t;

    typedef struct packed {
        logic                  enable;
        logic [COUNT_BITS-1:0] count;
        logic [CHORD_BITS-1:0] keys;
    } cell_cfg_t;

endpackage

// ----- rtl/key_chord_trigger_detector.sv -----
// ----------------------------------------------------------------------------
// key_chord_trigger_detector
// Reports which configured key chords are complete after each key event.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_kind, s_is_repeat, s_key_code
//   m_        out        m_valid / m_ready   m_fired
//   cfg_      in         cfg_wr_en           cfg_index, cfg_data
//
// One transaction per cycle sustained while m_ready stays high; each event walks
// the chain of trigger cells, through the stage register of each cell in turn.
// Each cell has its own stage register; a stall at m_ready backs up only
// until a bubble in the chain, so s_ready stays high while any stage is free.
// Synchronous active-low reset clears all marks, stage valids and config registers.
// ----------------------------------------------------------------------------
module key_chord_trigger_detector
    import kctd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic                      s_is_repeat,
    input  logic [CODE_BITS-1:0]      s_key_code,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FIRED_BITS-1:0]     m_fired
);

    logic [ENABLE_BITS-1:0] trigger_enable_reg;
    logic [COUNTS_BITS-1:0] key_counts_reg;
    logic [CHORD_BITS-1:0]  chord_keys_reg [CHORD_REGS];

    event_t    chain_event [TRIGGERS+1];
    logic      chain_valid [TRIGGERS+1];
    logic      chain_ready [TRIGGERS+1];
    cell_cfg_t cell_cfg    [TRIGGERS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_enable_reg <= '0;
            key_counts_reg     <= '0;
            for (int t = 0; t < CHORD_REGS; t++) begin
                chord_keys_reg[t] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIGGER_ENABLE: trigger_enable_reg <= cfg_data[ENABLE_BITS-1:0];
                REG_KEY_COUNTS:     key_counts_reg     <= cfg_data[COUNTS_BITS-1:0];
                REG_CHORD_KEYS_0:   chord_keys_reg[0]  <= cfg_data[CHORD_BITS-1:0];
                REG_CHORD_KEYS_1:   chord_keys_reg[1]  <= cfg_data[CHORD_BITS-1:0];
                REG_CHORD_KEYS_2:   chord_keys_reg[2]  <= cfg_data[CHORD_BITS-1:0];
                REG_CHORD_KEYS_3:   chord_keys_reg[3]  <= cfg_data[CHORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign chain_valid[0]       = s_valid;
    assign s_ready              = chain_ready[0];
    assign chain_event[0].kind      = s_kind;
    assign chain_event[0].is_repeat = s_is_repeat;
    assign chain_event[0].key       = s_key_code[KEY_BITS-1:0];
    assign chain_event[0].fired     = '0;

    for (genvar t = 0; t < TRIGGERS; t++) begin : g_cell
        assign cell_cfg[t].enable = trigger_enable_reg[t];
        assign cell_cfg[t].count  = key_counts_reg[COUNT_BITS*t +: COUNT_BITS];
        assign cell_cfg[t].keys   = chord_keys_reg[t];

        kctd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cell_cfg[t]),
            .in_valid  (chain_valid[t]),
            .in_ready  (chain_ready[t]),
            .in_event  (chain_event[t]),
            .out_valid (chain_valid[t+1]),
            .out_ready (chain_ready[t+1]),
            .out_event (chain_event[t+1])
        );
    end

    assign chain_ready[TRIGGERS] = m_ready;
    assign m_valid               = chain_valid[TRIGGERS];
    assign m_fired = FIRED_BITS'(chain_event[TRIGGERS].fired >> (FIRED_BITS - TRIGGERS));

endmodule

// ----- rtl/kctd_cell.sv -----
// ----------------------------------------------------------------------------
// kctd_cell
// One trigger of the chain: holds the marks of its chord, updates them from
// the passing key event and shifts its fire bit into the event's fired vector.
// ----------------------------------------------------------------------------
module kctd_cell
    import kctd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  event_t    in_event,
    output logic      out_valid,
    input  logic      out_ready,
    output event_t    out_event
);

    logic [KEYS_PER_TRIGGER-1:0] marks_reg;
    logic [KEYS_PER_TRIGGER-1:0] marks_next;
    logic                        valid_reg;
    logic                        valid_next;
    event_t                      event_reg;
    event_t                      event_next;

    logic [COUNT_BITS-1:0]       count_sat;
    logic [KEYS_PER_TRIGGER-1:0] used;
    logic [KEYS_PER_TRIGGER-1:0] match;
    logic                        take;
    logic                        fire;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_event = event_reg;

    always_comb begin
        if (cfg.count > COUNT_BITS'(KEYS_PER_TRIGGER)) begin
            count_sat = COUNT_BITS'(KEYS_PER_TRIGGER);
        end else begin
            count_sat = cfg.count;
        end
        for (int s = 0; s < KEYS_PER_TRIGGER; s++) begin
            used[s]  = COUNT_BITS'(s) < count_sat;
            match[s] = used[s] &&
                       (cfg.keys[SLOT_BITS*s +: KEY_BITS] == in_event.key);
        end
    end

    always_comb begin
        marks_next = marks_reg;
        fire       = 1'b0;
        if (take && cfg.enable) begin
            if (in_event.kind == KIND_DOWN) begin
                if (!in_event.is_repeat) begin
                    marks_next = (match != '0) ? (marks_reg | match) : '0;
                    fire       = (marks_next & used) == used;
                end
            end else begin
                marks_next = marks_reg & ~match;
            end
        end
    end

    always_comb begin
        event_next       = in_event;
        event_next.fired = {fire, in_event.fired[FIRED_BITS-1:1]};
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            marks_reg <= marks_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            event_reg <= event_next;
        end
    end

    a_disabled_marks_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(take && cfg.enable)) |-> (marks_reg == $past(marks_reg)))
        else $error("marks changed without an enabled transaction");

    a_fire_means_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(take) && event_reg.fired[FIRED_BITS-1])
            |-> ((marks_reg & $past(used)) == $past(used)))
        else $error("trigger fired with an incomplete chord");

    a_fire_only_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && event_reg.fired[FIRED_BITS-1])
            |-> (event_reg.kind == KIND_DOWN && !event_reg.is_repeat))
        else $error("trigger fired on a release or an autorepeat");

endmodule

// ----- tb/sv/tb_key_chord_trigger_detector.sv -----
// ----------------------------------------------------------------------------
// tb_key_chord_trigger_detector
// Self-checking bench for the key chord trigger detector. A behavioral
// predictor tracks chord tables and held marks per trigger and computes the
// fired mask of every accepted key event; results are compared in order.
// Directed chords cover key code extremes, repeats, zero-key and saturated
// chords, duplicate slots and disabled triggers; random chord sequences then
// run under several sender/receiver idling mixes and register settings.
// ----------------------------------------------------------------------------
module tb_key_chord_trigger_detector;
    import kctd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
    localparam int POOL_SIZE   = 6;
    localparam int CYCLE_LIMIT = 200000;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic                      s_kind      = KIND_DOWN;
    logic                      s_is_repeat = 1'b0;
    logic [CODE_BITS-1:0]      s_key_code  = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [FIRED_BITS-1:0]     m_fired;

    logic [ENABLE_BITS-1:0]      cfg_enable = '0;
    logic [COUNTS_BITS-1:0]      cfg_counts = '0;
    logic [CHORD_BITS-1:0]       cfg_chords [TRIGGERS];
    logic [KEYS_PER_TRIGGER-1:0] held_marks [TRIGGERS];
    logic [CODE_BITS-1:0]        key_pool [POOL_SIZE];
    logic [FIRED_BITS-1:0]       pending_fired [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int errors          = 0;
    int events_sent     = 0;
    int results_checked = 0;
    int firing_results  = 0;
    int regs_written    = 0;
    int cycle_count     = 0;

    key_chord_trigger_detector i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_is_repeat (s_is_repeat),
        .s_key_code  (s_key_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fired     (m_fired)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int t = 0; t < TRIGGERS; t++) begin
            cfg_chords[t] = '0;
            held_marks[t] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = '0;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int chord_len(input int t);
        int n;
        n = cfg_counts[COUNT_BITS*t +: COUNT_BITS];
        if (n > KEYS_PER_TRIGGER) begin
            n = KEYS_PER_TRIGGER;
        end
        return n;
    endfunction

    function automatic logic [KEYS_PER_TRIGGER-1:0] slot_hits(input int t,
                                                              input logic [CODE_BITS-1:0] key);
        logic [KEYS_PER_TRIGGER-1:0] hits;
        hits = '0;
        for (int s = 0; s < chord_len(t); s++) begin
            if (cfg_chords[t][SLOT_BITS*s +: KEY_BITS] == key[KEY_BITS-1:0]) begin
                hits[s] = 1'b1;
            end
        end
        return hits;
    endfunction

    function automatic logic [FIRED_BITS-1:0] predict_fired(input logic kind, input logic rep,
                                                           input logic [CODE_BITS-1:0] key);
        logic [FIRED_BITS-1:0]       fired;
        logic [KEYS_PER_TRIGGER-1:0] hits;
        logic [KEYS_PER_TRIGGER-1:0] used;
        fired = '0;
        for (int t = 0; t < TRIGGERS; t++) begin
            if (cfg_enable[t]) begin
                hits = slot_hits(t, key);
                used = KEYS_PER_TRIGGER'((1 << chord_len(t)) - 1);
                if (kind == KIND_UP) begin
                    held_marks[t] = held_marks[t] & ~hits;
                end else if (!rep) begin
                    held_marks[t] = (hits != '0) ? (held_marks[t] | hits) : '0;
                    if ((held_marks[t] & used) == used) begin
                        fired[t] = 1'b1;
                    end
                end
            end
        end
        return fired;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_fired.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual fired=%h",
                         $time, m_fired);
                errors++;
            end else begin
                if (m_fired !== pending_fired[0]) begin
                    $display("%0t: fired mismatch: expected %h, actual %h",
                             $time, pending_fired[0], m_fired);
                    errors++;
                end
                if (m_fired != '0) begin
                    firing_results++;
                end
                results_checked++;
                void'(pending_fired.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_event(input logic kind, input logic rep,
                              input logic [CODE_BITS-1:0] key);
        logic [FIRED_BITS-1:0] expected;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_is_repeat <= rep;
        s_key_code  <= key;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected      = predict_fired(kind, rep, key);
        pending_fired = {pending_fired, expected};
        events_sent++;
    endtask

    task automatic hold_off();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_fired.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_TRIGGER_ENABLE: cfg_enable = data[ENABLE_BITS-1:0];
            REG_KEY_COUNTS:     cfg_counts = data[COUNTS_BITS-1:0];
            REG_CHORD_KEYS_0:   cfg_chords[0] = data;
            REG_CHORD_KEYS_1:   cfg_chords[1] = data;
            REG_CHORD_KEYS_2:   cfg_chords[2] = data;
            REG_CHORD_KEYS_3:   cfg_chords[3] = data;
            default: ;
        endcase
        regs_written++;
    endtask

    task automatic test_reset_defaults();
        send_event(KIND_DOWN, 1'b0, 16'h0000);
        send_event(KIND_DOWN, 1'b0, 16'hFFFF);
        send_event(KIND_UP, 1'b1, 16'h0000);
    endtask

    task automatic test_directed_chords();
        hold_off();
        wait_drained();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        write_reg(REG_TRIGGER_ENABLE, 64'hF);
        // counts: two keys, zero keys, four keys, seven saturating to four
        write_reg(REG_KEY_COUNTS, 64'hF02);
        write_reg(REG_CHORD_KEYS_0, 64'h0000_0000_FFFF_0000);
        write_reg(REG_CHORD_KEYS_1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CHORD_KEYS_2, 64'h0004_0003_0002_0001);
        write_reg(REG_CHORD_KEYS_3, 64'h8000_8000_5555_AAAA);
        send_event(KIND_DOWN, 1'b0, 16'h0000);
        send_event(KIND_DOWN, 1'b0, 16'hFFFF);
        send_event(KIND_DOWN, 1'b1, 16'h0000);
        send_event(KIND_UP, 1'b1, 16'hFFFF);
        send_event(KIND_DOWN, 1'b0, 16'hFFFF);
        send_event(KIND_DOWN, 1'b0, 16'h0001);
        send_event(KIND_DOWN, 1'b0, 16'h0002);
        send_event(KIND_DOWN, 1'b0, 16'h0003);
        send_event(KIND_DOWN, 1'b0, 16'h0004);
        send_event(KIND_DOWN, 1'b0, 16'hAAAA);
        send_event(KIND_DOWN, 1'b0, 16'h5555);
        send_event(KIND_DOWN, 1'b0, 16'h8000);
        send_event(KIND_UP, 1'b0, 16'h8000);
        send_event(KIND_DOWN, 1'b0, 16'h1234);
    endtask

    task automatic test_disabled_triggers();
        send_event(KIND_DOWN, 1'b0, 16'hAAAA);
        send_event(KIND_DOWN, 1'b0, 16'h5555);
        hold_off();
        wait_drained();
        write_reg(REG_TRIGGER_ENABLE, 64'h7);
        send_event(KIND_DOWN, 1'b0, 16'h7777);
        send_event(KIND_UP, 1'b0, 16'h5555);
        hold_off();
        wait_drained();
        write_reg(REG_TRIGGER_ENABLE, 64'hF);
        send_event(KIND_DOWN, 1'b0, 16'h8000);
    endtask

    task automatic load_random_setting(input int setting);
        logic [ENABLE_BITS-1:0] en;
        logic [COUNTS_BITS-1:0] counts;
        logic [CHORD_BITS-1:0]  chords;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = CODE_BITS'($urandom_range(65535));
        end
        if (setting % 3 == 0) begin
            key_pool[0] = '0;
            key_pool[1] = '1;
        end
        en     = ENABLE_BITS'($urandom);
        counts = COUNTS_BITS'($urandom);
        case (setting)
            0: begin
                en     = '1;
                counts = '1;
            end
            3: begin
                en     = '1;
                counts = 12'o4444;
            end
            6: en = '0;
            9: begin
                en     = '1;
                counts = '0;
            end
            default: ;
        endcase
        write_reg(REG_TRIGGER_ENABLE, CFG_DATA_BITS'(en));
        write_reg(REG_KEY_COUNTS, CFG_DATA_BITS'(counts));
        for (int t = 0; t < TRIGGERS; t++) begin
            if (setting == 11) begin
                chords = {$urandom, $urandom};
            end else begin
                for (int s = 0; s < KEYS_PER_TRIGGER; s++) begin
                    chords[SLOT_BITS*s +: SLOT_BITS] = key_pool[$urandom_range(POOL_SIZE-1)];
                end
            end
            write_reg(REG_CHORD_KEYS_0 + CFG_INDEX_BITS'(t), chords);
        end
        if (setting % 4 == 1) begin
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
        end
    endtask

    task automatic run_random_events(input int n);
        int                   start_count;
        int                   t;
        int                   len;
        int                   j;
        int                   tmp;
        int                   order [KEYS_PER_TRIGGER];
        logic                 kind;
        logic                 rep;
        logic [CODE_BITS-1:0] code;
        start_count = events_sent;
        while (events_sent - start_count < n) begin
            if ($urandom_range(99) < 70) begin
                t   = $urandom_range(TRIGGERS-1);
                len = chord_len(t);
                for (int i = 0; i < KEYS_PER_TRIGGER; i++) begin
                    order[i] = i;
                end
                for (int i = len - 1; i > 0; i--) begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                if (len == 0) begin
                    send_event(KIND_DOWN, 1'b0, key_pool[$urandom_range(POOL_SIZE-1)]);
                end
                for (int i = 0; i < len; i++) begin
                    code = cfg_chords[t][SLOT_BITS*order[i] +: CODE_BITS];
                    if ($urandom_range(9) == 0) begin
                        send_event(KIND_DOWN, 1'b1, code);
                    end
                    send_event(KIND_DOWN, 1'b0, code);
                    if ($urandom_range(9) == 0) begin
                        send_event(KIND_UP, 1'($urandom_range(1)), code);
                        send_event(KIND_DOWN, 1'b0, code);
                    end
                end
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(1) == 1) begin
                        code = cfg_chords[t][SLOT_BITS*order[i] +: CODE_BITS];
                        send_event(KIND_UP, 1'($urandom_range(1)), code);
                    end
                end
            end else begin
                kind = $urandom_range(1) ? KIND_UP : KIND_DOWN;
                rep  = 1'($urandom_range(1));
                code = $urandom_range(1) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                         : CODE_BITS'($urandom_range(65535));
                send_event(kind, rep, code);
            end
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int first_setting);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int c = 0; c < 3; c++) begin
            hold_off();
            wait_drained();
            load_random_setting(first_setting + c);
            run_random_events(20);
            hold_off();
            wait_drained();
            run_random_events(20);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_chords();
        test_disabled_triggers();
        test_random_phase(0, 0, 0);
        test_random_phase(82, 0, 3);
        test_random_phase(0, 82, 6);
        test_random_phase(17, 17, 9);
        hold_off();
        wait_drained();
        repeat (4 * TRIGGERS) @(posedge aclk);
        $display("Run covered %0d key events, %0d results checked, %0d with triggers firing,",
                 events_sent, results_checked, firing_results);
        $display("%0d register writes across directed and 12 random chord settings",
                 regs_written);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
